FILE: rtl/gaussian_blur_border_normalized_top_defines.svh
// Assertion macros shared by the checker of the Gaussian blur block.
// Depends on nothing; included by the checker file.
`ifndef GAUSSIAN_BLUR_BORDER_NORMALIZED_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_BORDER_NORMALIZED_TOP_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define GBN_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("gbn checker: next-cycle property failed");

// Antecedent implies consequent in the same cycle.
`define GBN_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("gbn checker: same-cycle property failed");

`endif

FILE: rtl/gbn_pkg.sv
// Package of the Gaussian blur block: sizes, weight table, codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package gbn_pkg;

	localparam int MAX_RADIUS    = 3;
	localparam int WEIGHT_BITS   = 16;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int STORE_ROWS    = 2 * MAX_RADIUS + 2;
	localparam int SLOT_W        = $clog2(STORE_ROWS);
	localparam int WIDTH_W       = 11;
	localparam int HEIGHT_W      = 13;
	localparam int RAD_W         = 2;
	localparam int PIX_W         = 8;
	localparam int ROW_W         = HEIGHT_W;
	localparam int CFG_W         = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int K_W           = $clog2(MAX_RADIUS + 1) + 1;
	localparam int MAX_DIST      = 2 * MAX_RADIUS * MAX_RADIUS;
	localparam int DIST_W        = $clog2(MAX_DIST + 1);
	localparam int DEN_W         = WEIGHT_BITS + $clog2((2 * MAX_RADIUS + 1) ** 2);
	localparam int NUM_W         = DEN_W + PIX_W;
	localparam int QCNT_W        = $clog2(PIX_W);

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(512);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(512);
	localparam logic [RAD_W-1:0]    RADIUS_RESET = RAD_W'(1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_RADIUS = 2'd2
	} cfg_idx_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_MUL,
		S_CHK,
		S_TAP,
		S_FLUSH,
		S_DIV,
		S_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic update;
		logic mul;
		logic clear;
		logic tap_start;
		logic tap_step;
		logic div_start;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic drop;
		logic out_over;
		logic emit_ok;
		logic tap_last;
		logic pipe_busy;
		logic div_last;
		logic out_free;
	} dp_sts_t;

	// Weights exp(-d / (2 r^2)) in unsigned Q1.15, one row per radius.
	localparam logic [WEIGHT_BITS-1:0] W_R1 [0:MAX_DIST] = '{
		0: 16'd32768, 1: 16'd19875, 2: 16'd12055, default: 16'd0
	};
	localparam logic [WEIGHT_BITS-1:0] W_R2 [0:MAX_DIST] = '{
		0: 16'd32768, 1: 16'd28918, 2: 16'd25520, 3: 16'd22521, 4: 16'd19875,
		5: 16'd17539, 6: 16'd15479, 7: 16'd13660, 8: 16'd12055, default: 16'd0
	};
	localparam logic [WEIGHT_BITS-1:0] W_R3 [0:MAX_DIST] = '{
		0: 16'd32768, 1: 16'd30997, 2: 16'd29322, 3: 16'd27738, 4: 16'd26239,
		5: 16'd24821, 6: 16'd23479, 7: 16'd22210, 8: 16'd21010, 9: 16'd19875,
		10: 16'd18801, 11: 16'd17785, 12: 16'd16824, 13: 16'd15914, 14: 16'd15054,
		15: 16'd14241, 16: 16'd13471, 17: 16'd12743, 18: 16'd12055
	};

	// Weight lookup for a given radius and squared tap distance.
	function automatic logic [WEIGHT_BITS-1:0] gauss_weight(
		input logic [RAD_W-1:0]  r,
		input logic [DIST_W-1:0] d
	);
		logic [WEIGHT_BITS-1:0] w;
		w = '0;
		if (d <= DIST_W'(MAX_DIST)) begin
			case (r)
				2'd1: w = W_R1[d];
				2'd2: w = W_R2[d];
				2'd3: w = W_R3[d];
				default: w = '0;
			endcase
		end
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gaussian_blur_border_normalized_top.sv
// Gaussian blur with border renormalization, 8-bit grey raster stream.
// One item at a time: a pixel that yields a result goes from transfer to output
// through the tap sweep, which reads one line-store word a cycle, and a restoring
// divider; an item with no result goes back to idle after the window check.
// Reset clears counters and output valid, loads width 512, height 512,
// radius 1; the line store is not cleared.
`default_nettype none

module gaussian_blur_border_normalized_top import gbn_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 mode,
	input  wire logic [PIX_W-1:0]     pixel_in,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [PIX_W-1:0]     pixel_out,
	output logic                      frame_end
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer.
	gbn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath.
	gbn_dp #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.mode     (mode),
		.pixel_in (pixel_in),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.pixel_out(pixel_out),
		.frame_end(frame_end),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

`default_nettype wire

FILE: rtl/gbn_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module gbn_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [0:DEPTH-1];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/gbn_ctrl.sv
// Controller of the Gaussian blur block: sequences one item through update,
// window check, tap sweep, division and output. Depends on gbn_pkg.
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	ctrl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.drop) begin
					state_d = S_IDLE;
				end else if (sts.out_over) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end else if (!sts.emit_ok) begin
					state_d = S_IDLE;
				end else begin
					cmd.tap_start = 1'b1;
					state_d       = S_TAP;
				end
			end
			S_TAP: begin
				cmd.tap_step = 1'b1;
				if (sts.tap_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!sts.pipe_busy) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/gbn_dp.sv
// Datapath of the Gaussian blur block: configuration, counters, line store,
// tap pipeline, accumulators, divider and output register.
// Depends on gbn_pkg and gbn_ram.
`default_nettype none

module gbn_dp import gbn_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 mode,
	input  wire logic [PIX_W-1:0]     pixel_in,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic      [PIX_W-1:0]     pixel_out,
	output logic                      frame_end,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int AW    = SLOT_W + CW;
	localparam int DEPTH = STORE_ROWS * (1 << CW);
	localparam int PW    = ROW_W + CW + 1;
	localparam int PRD_W = WEIGHT_BITS + PIX_W;

	// Configuration registers.
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [RAD_W-1:0]    rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			rad_q    <= RADIUS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_RADIUS: rad_q    <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry after the zero and saturation rules.
	logic [CW:0]         w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [RAD_W-1:0]    r_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = (CW + 1)'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = (CW + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW + 1)'(width_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		if (rad_q == '0) begin
			r_eff = RAD_W'(1);
		end else if (32'(rad_q) > MAX_RADIUS) begin
			r_eff = RAD_W'(MAX_RADIUS);
		end else begin
			r_eff = rad_q;
		end
	end

	// Latched input item.
	logic             mode_q;
	logic [PIX_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode;
			pix_q  <= pixel_in;
		end
	end

	// Position counters.
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [CW-1:0]    in_col_q, out_col_q;
	logic             drop_q;

	// Row wrap of the counters and the store write, for the update step.
	logic [ROW_W-1:0] ir0, or0, ir_new;
	logic [CW-1:0]    ic0, oc0, ic_new;
	logic             in_done, store_we;
	logic [CW:0]      ic_inc;

	always_comb begin
		if ({1'b0, in_col_q} >= w_eff) begin
			ic0 = '0;
			ir0 = in_row_q + ROW_W'(1);
		end else begin
			ic0 = in_col_q;
			ir0 = in_row_q;
		end
		if ({1'b0, out_col_q} >= w_eff) begin
			oc0 = '0;
			or0 = out_row_q + ROW_W'(1);
		end else begin
			oc0 = out_col_q;
			or0 = out_row_q;
		end
		in_done  = ir0 >= h_eff;
		store_we = cmd.update && !in_done && !mode_q;
		ic_inc   = {1'b0, ic0} + (CW + 1)'(1);
		ic_new   = ic0;
		ir_new   = ir0;
		if (!in_done && !mode_q) begin
			if (ic_inc >= w_eff) begin
				ic_new = '0;
				ir_new = ir0 + ROW_W'(1);
			end else begin
				ic_new = ic_inc[CW-1:0];
			end
		end
	end

	// Output advance after a result.
	logic [CW:0]      oc_inc;
	logic [ROW_W:0]   or_inc;
	logic             row_wrap, frame_last;

	always_comb begin
		oc_inc     = {1'b0, out_col_q} + (CW + 1)'(1);
		or_inc     = {1'b0, out_row_q} + (ROW_W + 1)'(1);
		row_wrap   = oc_inc >= w_eff;
		frame_last = row_wrap && (or_inc >= {1'b0, h_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			drop_q    <= 1'b0;
		end else if (cmd.update) begin
			in_row_q  <= ir_new;
			in_col_q  <= ic_new;
			out_row_q <= or0;
			out_col_q <= oc0;
			drop_q    <= !in_done && mode_q;
		end else if (cmd.clear || (cmd.emit && frame_last)) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cmd.emit) begin
			if (row_wrap) begin
				out_col_q <= '0;
				out_row_q <= or_inc[ROW_W-1:0];
			end else begin
				out_col_q <= oc_inc[CW-1:0];
			end
		end
	end

	// Window check: stream positions as row times width plus column.
	logic [PW-1:0] prod_a_q, prod_b_q;
	logic [CW+RAD_W:0] lag_q;
	logic [PW+1:0] received, pos_lag;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_a_q <= PW'(in_row_q * w_eff);
			prod_b_q <= PW'(out_row_q * w_eff);
			lag_q    <= (CW + RAD_W + 1)'(r_eff * w_eff) + (CW + RAD_W + 1)'(r_eff);
		end
	end

	always_comb begin
		received = (PW + 2)'(prod_a_q) + (PW + 2)'(in_col_q);
		pos_lag  = (PW + 2)'(prod_b_q) + (PW + 2)'(out_col_q) + (PW + 2)'(lag_q);
	end

	// Tap sweep over the window, row by row.
	logic signed [K_W-1:0] k_q, l_q, rk;
	logic [K_W-1:0]        ak, al;
	logic [2*K_W-1:0]      sq_k, sq_l;
	logic [DIST_W-1:0]     tap_dist;
	logic signed [ROW_W+1:0] ty;
	logic signed [CW+1:0]    tx;
	logic                  tap_ok;
	logic [AW-1:0]         raddr;
	logic [WEIGHT_BITS-1:0] tap_wt;

	always_comb begin
		rk       = signed'(K_W'(r_eff));
		ak       = (k_q < 0) ? K_W'(-k_q) : K_W'(k_q);
		al       = (l_q < 0) ? K_W'(-l_q) : K_W'(l_q);
		sq_k     = ak * ak;
		sq_l     = al * al;
		tap_dist = DIST_W'(sq_k) + DIST_W'(sq_l);
		ty       = signed'({2'b00, out_row_q}) + (ROW_W + 2)'(k_q);
		tx       = signed'({2'b00, out_col_q}) + (CW + 2)'(l_q);
		tap_ok   = (ty >= 0) && (ty < signed'({2'b00, h_eff}))
			&& (tx >= 0) && (tx < signed'({1'b0, w_eff}));
		raddr    = {ty[SLOT_W-1:0], tx[CW-1:0]};
		tap_wt   = tap_ok ? gauss_weight(r_eff, tap_dist) : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.tap_start) begin
			k_q <= -rk;
			l_q <= -rk;
		end else if (cmd.tap_step) begin
			if (l_q == rk) begin
				l_q <= -rk;
				k_q <= k_q + K_W'(1);
			end else begin
				l_q <= l_q + K_W'(1);
			end
		end
	end

	// Line store.
	logic [PIX_W-1:0] ram_rdata;

	gbn_ram #(
		.DATA_W(PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr({ir0[SLOT_W-1:0], ic0}),
		.wdata(pix_q),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Tap pipeline: read, multiply, accumulate.
	logic                   busy_s1, busy_s2;
	logic                   ok_s1;
	logic [WEIGHT_BITS-1:0] wt_s1, wt_s2;
	logic [PRD_W-1:0]       prod_s2;
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			busy_s2 <= 1'b0;
		end else begin
			busy_s1 <= cmd.tap_step;
			busy_s2 <= busy_s1;
		end
	end

	// Taps outside the image read an arbitrary store word, so their data is masked.
	always_ff @(posedge clk) begin
		wt_s1   <= tap_wt;
		ok_s1   <= tap_ok;
		wt_s2   <= wt_s1;
		prod_s2 <= wt_s1 * (ok_s1 ? ram_rdata : PIX_W'(0));
		if (cmd.tap_start) begin
			num_q <= '0;
			den_q <= '0;
		end else if (busy_s2) begin
			num_q <= num_q + NUM_W'(prod_s2);
			den_q <= den_q + DEN_W'(wt_s2);
		end
	end

	// Restoring division, one quotient bit per cycle.
	logic [NUM_W-1:0]  rem_q, den_sh;
	logic [PIX_W-1:0]  quo_q;
	logic [QCNT_W-1:0] div_cnt_q;
	logic              q_bit;

	always_comb begin
		den_sh = NUM_W'(den_q) << div_cnt_q;
		q_bit  = rem_q >= den_sh;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q     <= num_q;
			quo_q     <= '0;
			div_cnt_q <= QCNT_W'(PIX_W - 1);
		end else if (cmd.div_step) begin
			if (q_bit) begin
				rem_q <= rem_q - den_sh;
			end
			quo_q     <= {quo_q[PIX_W-2:0], q_bit};
			div_cnt_q <= div_cnt_q - QCNT_W'(1);
		end
	end

	// Output register.
	logic out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_q     <= (den_q == '0) ? '0 : quo_q;
			frame_end_q <= frame_last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign frame_end = frame_end_q;

	// Status to the controller.
	always_comb begin
		sts           = '0;
		sts.drop      = drop_q;
		sts.out_over  = out_row_q >= h_eff;
		sts.emit_ok   = !((in_row_q < h_eff) && (received <= pos_lag));
		sts.tap_last  = (k_q == rk) && (l_q == rk);
		sts.pipe_busy = busy_s1 || busy_s2;
		sts.div_last  = div_cnt_q == '0;
		sts.out_free  = !out_valid_q || !out_stall;
	end

endmodule

`default_nettype wire

FILE: rtl/gbn_checker.sv
// Port-level checker for the Gaussian blur block, bound to the top level.
// Depends on gbn_pkg and the assertion macros header.
`default_nettype none
`include "gaussian_blur_border_normalized_top_defines.svh"

module gbn_checker import gbn_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [PIX_W-1:0]     pixel_out,
	input wire logic                 frame_end
);

	// A stalled result holds its value until transfer.
	`GBN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pixel_out) && $stable(frame_end))

	// After an input transfer the block is busy with that item.
	`GBN_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)

	// A new result only comes out of a busy cycle.
	`GBN_ASSERT_NOW(a_out_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind gaussian_blur_border_normalized_top gbn_checker u_gbn_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the Gaussian blur block with border renormalization.
// Depends on gbn_pkg and gaussian_blur_border_normalized_top; builds its own
// reference of the filter and checks every output transfer against it.
`timescale 1ns / 100ps

module tb;
	import gbn_pkg::*;

	typedef struct {
		bit       drain;
		bit [7:0] pix;
	} pix_item_t;

	typedef struct {
		bit [7:0] pix;
		bit       last;
	} blur_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 mode = 1'b0;
	logic [PIX_W-1:0]     pixel_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PIX_W-1:0]     pixel_out;
	logic                 frame_end;

	gaussian_blur_border_normalized_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_out(pixel_out), .frame_end(frame_end)
	);

	always #2 clk = ~clk;

	// Pending input transfers and the blurred pixels they are expected to produce.
	pix_item_t    pix_q[$];
	blur_result_t blur_q[$];
	int           errors = 0;
	int           results_seen = 0;

	// Shadow of the filter: registers, counters, line store and weights.
	int unsigned  sh_width = 512, sh_height = 512, sh_radius = 1;
	int unsigned  in_row, in_col, out_row, out_col;
	bit [7:0]     rows_buf [0:8*1024-1];
	int unsigned  wtab [1:3][0:18];
	bit           frame_closed;

	// Truncated alternating series of exp(-d/den), rounded to Q1.15.
	function automatic int unsigned series_weight(int unsigned d, int unsigned den);
		longint unsigned term, acc;
		term = 64'd1 << 56;
		acc = term;
		for (int n = 1; n <= 40; n++) begin
			term = term * d / (longint'(den) * n);
			if (n % 2) acc -= term;
			else acc += term;
		end
		return int'((acc + (64'd1 << 40)) >> 41);
	endfunction

	function automatic int unsigned eff_width();
		return (sh_width == 0) ? 1 : (sh_width > 1024) ? 1024 : sh_width;
	endfunction

	function automatic int unsigned eff_height();
		return (sh_height == 0) ? 1 : sh_height;
	endfunction

	function automatic int unsigned eff_radius();
		return (sh_radius == 0) ? 1 : (sh_radius > 3) ? 3 : sh_radius;
	endfunction

	// Advance the shadow filter by one input transfer.
	task automatic blur_step(bit drain, bit [7:0] pix);
		int unsigned w, h, r;
		longint rcv, pos, lag;
		longint unsigned num, den;
		int y, x;
		int unsigned wt;
		blur_result_t res;
		w = eff_width();
		h = eff_height();
		r = eff_radius();
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		if (in_row < h) begin
			if (drain) return;
			rows_buf[(in_row % 8) * 1024 + in_col] = pix;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		if (out_row >= h) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
			return;
		end
		rcv = longint'(in_row) * w + in_col;
		pos = longint'(out_row) * w + out_col;
		lag = longint'(r) * w + r;
		if (in_row < h && rcv <= pos + lag) return;
		num = 0;
		den = 0;
		for (int k = -int'(r); k <= int'(r); k++) begin
			y = int'(out_row) + k;
			if (y < 0 || y >= int'(h)) continue;
			for (int l = -int'(r); l <= int'(r); l++) begin
				x = int'(out_col) + l;
				if (x < 0 || x >= int'(w)) continue;
				wt = wtab[r][k * k + l * l];
				num += longint'(wt) * rows_buf[(y % 8) * 1024 + x];
				den += wt;
			end
		end
		res.pix = 8'(num / den);
		res.last = 1'b0;
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) begin
				res.last = 1'b1;
				frame_closed = 1'b1;
				in_row = 0; in_col = 0; out_row = 0; out_col = 0;
			end
		end
		blur_q.push_back(res);
	endtask

	// Queue one input transfer; transfers are accepted in order, so predict now.
	task automatic add_pixel(bit drain, bit [7:0] pix);
		pix_item_t it;
		it.drain = drain;
		it.pix = pix;
		blur_step(drain, pix);
		pix_q.push_back(it);
	endtask

	function automatic bit [7:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// One whole frame, a few ignored drain ticks inside it, then the flush.
	task automatic send_frame(int items_extra);
		int unsigned npix;
		npix = eff_width() * eff_height();
		frame_closed = 1'b0;
		for (int unsigned i = 0; i < npix; i++) begin
			if ($urandom_range(0, 24) == 0) add_pixel(1'b1, rand_pixel());
			add_pixel(1'b0, rand_pixel());
		end
		// After the last pixel, a pixel transfer acts like a drain tick.
		while (!frame_closed) add_pixel(1'($urandom_range(0, 1)), rand_pixel());
		repeat (items_extra) add_pixel(1'b1, rand_pixel());
	endtask

	// Register write; width and radius writes carry random bits above the field width.
	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		case (idx)
			CFG_WIDTH: begin
				cfg_data <= {2'($urandom), 11'(val)};
				sh_width = val & 32'h7FF;
			end
			CFG_HEIGHT: begin
				cfg_data <= 13'(val);
				sh_height = val & 32'h1FFF;
			end
			default: begin
				cfg_data <= {11'($urandom), 2'(val)};
				sh_radius = val & 32'h3;
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Let the block drain completely before touching its registers.
	task automatic wait_idle();
		while (pix_q.size() != 0 || blur_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned w, int unsigned h, int unsigned r, int frames);
		wait_idle();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_RADIUS, r);
		repeat (frames) send_frame($urandom_range(0, 2));
	endtask

	// Stimulus: reset, directed settings, then random small frames.
	initial begin
		int sent_random;
		for (int r = 1; r <= 3; r++)
			for (int d = 0; d <= 2 * r * r; d++)
				wtab[r][d] = series_weight(d, 2 * r * r);
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Tiny frames, degenerate registers and tall narrow frames.
		run_phase(3, 2, 1, 1);
		run_phase(1, 1, 1, 1);
		run_phase(0, 0, 0, 1);
		run_phase(3, 4, 3, 1);
		run_phase(1, 9, 2, 1);
		run_phase(8, 1, 3, 1);
		run_phase(1, 40, 3, 1);
		run_phase(7, 6, 2, 2);

		sent_random = 0;
		while (sent_random < 880) begin
			int unsigned w, h;
			int nfr;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			nfr = $urandom_range(1, 3);
			run_phase(w, h, $urandom_range(0, 3), nfr);
			sent_random += int'(w * h) * nfr;
		end

		wait_idle();
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	// Sender gap picker: mostly back to back, some short, a few long pauses.
	bit quiet_run = 1'b0;
	function automatic int pick_gap();
		int p;
		if ($urandom_range(0, 149) == 0) quiet_run = ~quiet_run;
		if (quiet_run) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 90) return $urandom_range(1, 3);
		if (p < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Input driver: offer the head of the pending queue, hold it while stalled.
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) pix_q.pop_front();
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pix_q.size() > 0 && !(in_valid && !in_stall && pix_q.size() == 0)) begin
					in_valid <= 1'b1;
					mode <= pix_q[0].drain;
					pixel_in <= pix_q[0].pix;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and receiver stall, with one long hold-off.
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  calm_run = 1'b0;
	always @(posedge clk) begin
		blur_result_t exp_res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (blur_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer pixel_out=%0d frame_end=%0d",
						$time, pixel_out, frame_end);
				end else begin
					exp_res = blur_q.pop_front();
					if (pixel_out !== exp_res.pix) begin
						errors++;
						$display("%0t: pixel_out expected %0d actual %0d",
							$time, exp_res.pix, pixel_out);
					end
					if (frame_end !== exp_res.last) begin
						errors++;
						$display("%0t: frame_end expected %0d actual %0d",
							$time, exp_res.last, frame_end);
					end
				end
			end
			if ($urandom_range(0, 149) == 0) calm_run = ~calm_run;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= 40) begin
				hold_done = 1'b1;
				hold_left = 700;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm_run && $urandom_range(0, 3) == 0) begin
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any transfer means the block is stuck.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= 5000) begin
			$display("DONE: errors detected");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/gbn_pkg.sv
rtl/gbn_ram.sv
rtl/gbn_ctrl.sv
rtl/gbn_dp.sv
rtl/gaussian_blur_border_normalized_top.sv
rtl/gbn_checker.sv
tb/tb.sv
